/* sv/tpvs_pkg.sv */
`default_nettype none

package tpvs_pkg;

   localparam int unsigned DUR_W     = 16;
   localparam int unsigned NUM_DUR   = 6;
   localparam int unsigned SUM_W     = 19;
   localparam int unsigned ELAPSED_W = 20;
   localparam int unsigned LEVEL_W   = 6;
   localparam int unsigned CSR_IDX_W = 3;

   typedef logic [DUR_W-1:0]     dur_type;
   typedef logic [SUM_W-1:0]     sum_type;
   typedef logic [ELAPSED_W-1:0] elapsed_type;
   typedef logic [LEVEL_W-1:0]   level_type;

   localparam dur_type DUR_RESET [NUM_DUR] = '{
      16'd15000, 16'd3000, 16'd7000, 16'd10000, 16'd500, 16'd0
   };

   // duration slots
   localparam int unsigned DUR_AIR       = 0;
   localparam int unsigned DUR_PAUSE_ONE = 1;
   localparam int unsigned DUR_WATER     = 2;
   localparam int unsigned DUR_PAUSE_TWO = 3;
   localparam int unsigned DUR_COOLING   = 4;
   localparam int unsigned DUR_TAIL      = 5;

   // level bit positions
   localparam int unsigned LV_AIR     = 0;
   localparam int unsigned LV_VALVE   = 1;
   localparam int unsigned LV_WATER   = 2;
   localparam int unsigned LV_COLLECT = 3;
   localparam int unsigned LV_COOL    = 4;
   localparam int unsigned LV_COOLCOL = 5;

   localparam logic [7:0] BTN_START         = 8'd1;
   localparam logic [7:0] BTN_START_ASCII   = 8'd49;
   localparam logic [7:0] BTN_RESET         = 8'd2;
   localparam logic [7:0] BTN_RESET_ASCII   = 8'd50;
   localparam logic [7:0] BTN_COLLECT       = 8'd4;
   localparam logic [7:0] BTN_COLLECT_ASCII = 8'd52;

   localparam logic [1:0] PRESS_NONE   = 2'd0;
   localparam logic [1:0] PRESS_START  = 2'd1;
   localparam logic [1:0] PRESS_PAUSE  = 2'd2;
   localparam logic [1:0] PRESS_RESUME = 2'd3;

   localparam logic ACTION_TICK = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_AIR     = 3'd1,
      ST_WATER   = 3'd2,
      ST_COLLECT = 3'd3,
      ST_ENDED   = 3'd4
   } status_type;

endpackage

`default_nettype wire

/* sv/timed_pump_valve_sequencer.sv */
// the result of an item is registered and shown in the cycle after acceptance
// one item per cycle while rsp_ready is high; phase update and compares: single stage
// phase boundaries are running sums held in registers, refreshed with each duration write
// reset: synchronous, active high; clears all sequence state and the result register,
// and returns the six durations to their default values
`default_nettype none

module timed_pump_valve_sequencer (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_action,
   input  wire logic [7:0]                         req_button_code,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_air_motor_pin,
   output logic                                    rsp_valve_pin,
   output logic                                    rsp_water_pump_pin,
   output logic                                    rsp_collect_pump_pin,
   output logic                                    rsp_cooling_pump_pin,
   output logic                                    rsp_cooling_collect_pin,
   output logic                                    rsp_running,
   output logic [2:0]                              rsp_status_code,
   input  wire logic                               csr_we,
   input  wire logic [tpvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tpvs_pkg::DUR_W-1:0]         csr_wdata
);

   tpvs_pkg::dur_type     dur_ff [tpvs_pkg::NUM_DUR];
   tpvs_pkg::dur_type     dur_in [tpvs_pkg::NUM_DUR];
   tpvs_pkg::sum_type     sum_ff [tpvs_pkg::NUM_DUR];
   tpvs_pkg::sum_type     sum_in [tpvs_pkg::NUM_DUR];

   tpvs_pkg::elapsed_type elapsed_ff, elapsed_in;
   logic                  active_ff, active_in;
   logic                  timer_ff, timer_in;
   logic [1:0]            press_ff, press_in;
   tpvs_pkg::level_type   levels_ff, levels_in;
   tpvs_pkg::level_type   pins_ff, pins_in;
   tpvs_pkg::status_type  status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_fire;
   logic                  btn_start, btn_reset, btn_collect;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // duration registers and running sums
   always_comb begin
      for (int i = 0; i < tpvs_pkg::NUM_DUR; i++) begin
         if (reset) begin
            dur_in[i] = tpvs_pkg::DUR_RESET[i];
         end else if (csr_we && csr_index == tpvs_pkg::CSR_IDX_W'(i)) begin
            dur_in[i] = csr_wdata;
         end else begin
            dur_in[i] = dur_ff[i];
         end
      end
      sum_in[0] = tpvs_pkg::SUM_W'(dur_in[0]);
      for (int i = 1; i < tpvs_pkg::NUM_DUR; i++) begin
         sum_in[i] = sum_in[i-1] + tpvs_pkg::SUM_W'(dur_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      dur_ff <= dur_in;
      sum_ff <= sum_in;
   end

   assign btn_start   = req_button_code == tpvs_pkg::BTN_START ||
                        req_button_code == tpvs_pkg::BTN_START_ASCII;
   assign btn_reset   = req_button_code == tpvs_pkg::BTN_RESET ||
                        req_button_code == tpvs_pkg::BTN_RESET_ASCII;
   assign btn_collect = req_button_code == tpvs_pkg::BTN_COLLECT ||
                        req_button_code == tpvs_pkg::BTN_COLLECT_ASCII;

   always_comb begin
      elapsed_in = elapsed_ff;
      active_in  = active_ff;
      timer_in   = timer_ff;
      press_in   = press_ff;
      levels_in  = levels_ff;
      pins_in    = pins_ff;
      status_in  = status_ff;

      if (req_action == tpvs_pkg::ACTION_TICK) begin
         if (timer_ff && elapsed_ff != '1) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end else begin
         priority if (btn_start) begin
            press_in = press_ff + 2'd1;
            priority if (press_in == tpvs_pkg::PRESS_START) begin
               active_in = 1'b1;
            end else if (press_in == tpvs_pkg::PRESS_PAUSE) begin
               timer_in  = 1'b0;
               pins_in   = '0;
               active_in = 1'b0;
            end else if (press_in == tpvs_pkg::PRESS_RESUME) begin
               timer_in  = 1'b1;
               active_in = 1'b1;
               press_in  = tpvs_pkg::PRESS_START;
            end else begin
               press_in = tpvs_pkg::PRESS_NONE;
            end
         end else if (btn_reset) begin
            elapsed_in = '0;
            active_in  = 1'b0;
            timer_in   = 1'b0;
            press_in   = tpvs_pkg::PRESS_NONE;
            levels_in  = '0;
            pins_in    = '0;
            status_in  = tpvs_pkg::ST_IDLE;
         end else if (btn_collect) begin
            status_in                       = tpvs_pkg::ST_COLLECT;
            levels_in[tpvs_pkg::LV_COLLECT] = 1'b1;
            levels_in[tpvs_pkg::LV_COOLCOL] = 1'b1;
            pins_in[tpvs_pkg::LV_COLLECT]   = 1'b1;
            pins_in[tpvs_pkg::LV_COOLCOL]   = 1'b1;
         end else begin
            press_in = press_ff;
         end
      end

      // phase selection
      if (active_in) begin
         if (elapsed_in == '0) begin
            timer_in = 1'b1;
         end
         priority if (elapsed_in < tpvs_pkg::ELAPSED_W'(sum_ff[tpvs_pkg::DUR_AIR])) begin
            status_in                   = tpvs_pkg::ST_AIR;
            levels_in[tpvs_pkg::LV_AIR] = 1'b1;
         end else if (elapsed_in < tpvs_pkg::ELAPSED_W'(sum_ff[tpvs_pkg::DUR_PAUSE_ONE])) begin
            levels_in[tpvs_pkg::LV_AIR] = 1'b0;
         end else if (elapsed_in < tpvs_pkg::ELAPSED_W'(sum_ff[tpvs_pkg::DUR_WATER])) begin
            levels_in[tpvs_pkg::LV_VALVE]   = 1'b1;
            levels_in[tpvs_pkg::LV_WATER]   = 1'b1;
            levels_in[tpvs_pkg::LV_COLLECT] = 1'b1;
            status_in                       = tpvs_pkg::ST_WATER;
         end else if (elapsed_in < tpvs_pkg::ELAPSED_W'(sum_ff[tpvs_pkg::DUR_PAUSE_TWO])) begin
            levels_in[tpvs_pkg::LV_WATER] = 1'b0;
         end else if (elapsed_in < tpvs_pkg::ELAPSED_W'(sum_ff[tpvs_pkg::DUR_COOLING])) begin
            levels_in[tpvs_pkg::LV_COLLECT] = 1'b0;
            levels_in[tpvs_pkg::LV_COOL]    = 1'b1;
            levels_in[tpvs_pkg::LV_COOLCOL] = 1'b1;
         end else if (elapsed_in < tpvs_pkg::ELAPSED_W'(sum_ff[tpvs_pkg::DUR_TAIL])) begin
            levels_in[tpvs_pkg::LV_COOL] = 1'b0;
         end else begin
            levels_in[tpvs_pkg::LV_VALVE]   = 1'b0;
            levels_in[tpvs_pkg::LV_COOLCOL] = 1'b0;
            status_in                       = tpvs_pkg::ST_ENDED;
            active_in                       = 1'b0;
            timer_in                        = 1'b0;
            elapsed_in                      = '0;
         end
         pins_in = levels_in;
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         active_ff    <= 1'b0;
         timer_ff     <= 1'b0;
         press_ff     <= tpvs_pkg::PRESS_NONE;
         levels_ff    <= '0;
         pins_ff      <= '0;
         status_ff    <= tpvs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            elapsed_ff <= elapsed_in;
            active_ff  <= active_in;
            timer_ff   <= timer_in;
            press_ff   <= press_in;
            levels_ff  <= levels_in;
            pins_ff    <= pins_in;
            status_ff  <= status_in;
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_air_motor_pin       = pins_ff[tpvs_pkg::LV_AIR];
   assign rsp_valve_pin           = pins_ff[tpvs_pkg::LV_VALVE];
   assign rsp_water_pump_pin      = pins_ff[tpvs_pkg::LV_WATER];
   assign rsp_collect_pump_pin    = pins_ff[tpvs_pkg::LV_COLLECT];
   assign rsp_cooling_pump_pin    = pins_ff[tpvs_pkg::LV_COOL];
   assign rsp_cooling_collect_pin = pins_ff[tpvs_pkg::LV_COOLCOL];
   assign rsp_running             = active_ff;
   assign rsp_status_code         = status_ff;

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_active_press: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> press_ff == tpvs_pkg::PRESS_START)
      else $error("sequence active with press count other than start");

   a_press_range: assert property (@(posedge clock) disable iff (reset)
      press_ff != tpvs_pkg::PRESS_RESUME)
      else $error("press count held at resume");

   a_timer_needs_run: assert property (@(posedge clock) disable iff (reset)
      timer_ff |-> active_ff)
      else $error("timer enabled while sequence inactive");

endmodule

`default_nettype wire
